>>> rtl/core/ddo_pkg.sv
// Shared constants, control word types, microcode ROM and arctangent table for the odometry core.
package ddo_pkg;

    // Fixed-point constants (Q2.16 radians unless noted)
    localparam int PI_Q        = 205887;
    localparam int TWO_PI_Q    = 411775;
    localparam int HALF_PI_Q   = 102944;
    localparam int CORDIC_GAIN = 652032874;   // Q2.30

    // CORDIC iteration count, capped by the length of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int ITERS        = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int ITER_W       = (ITERS > 1) ? $clog2(ITERS) : 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_AXIS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RADIUS_RESET  = 16'd1311;
    localparam logic [23:0] INV_AXIS_RESET = 24'd1260307;

    // Microcode program counter
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_LATCH  = 4'd0;
    localparam logic [PC_W-1:0] PC_ROTATE = 4'd6;
    localparam logic [PC_W-1:0] PC_EMIT   = 4'd10;

    // Datapath operation of one step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_TRAVEL_L,
        OP_TRAVEL_R,
        OP_MIX,
        OP_TURN,
        OP_FOLD,
        OP_ROTATE,
        OP_UNFOLD,
        OP_MOVE_X,
        OP_MOVE_Y,
        OP_EMIT
    } op_t;

    // Hold condition: the step waits here until it is met
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_t;

    // Sequencing after the step has executed
    typedef enum logic [1:0] {
        BR_NEXT,
        BR_LOOP,
        BR_ALWAYS
    } branch_t;

    typedef struct packed {
        op_t             op;
        wait_t           hold;
        branch_t         branch;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Program: one control word per step
    function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, hold: WAIT_NONE, branch: BR_ALWAYS, target: PC_LATCH};
        case (pc)
            4'd0:    w = '{op: OP_LATCH,    hold: WAIT_IN,   branch: BR_NEXT,   target: PC_LATCH};
            4'd1:    w = '{op: OP_TRAVEL_L, hold: WAIT_NONE, branch: BR_NEXT,   target: PC_LATCH};
            4'd2:    w = '{op: OP_TRAVEL_R, hold: WAIT_NONE, branch: BR_NEXT,   target: PC_LATCH};
            4'd3:    w = '{op: OP_MIX,      hold: WAIT_NONE, branch: BR_NEXT,   target: PC_LATCH};
            4'd4:    w = '{op: OP_TURN,     hold: WAIT_NONE, branch: BR_NEXT,   target: PC_LATCH};
            4'd5:    w = '{op: OP_FOLD,     hold: WAIT_NONE, branch: BR_NEXT,   target: PC_LATCH};
            4'd6:    w = '{op: OP_ROTATE,   hold: WAIT_NONE, branch: BR_LOOP,   target: PC_ROTATE};
            4'd7:    w = '{op: OP_UNFOLD,   hold: WAIT_NONE, branch: BR_NEXT,   target: PC_LATCH};
            4'd8:    w = '{op: OP_MOVE_X,   hold: WAIT_NONE, branch: BR_NEXT,   target: PC_LATCH};
            4'd9:    w = '{op: OP_MOVE_Y,   hold: WAIT_NONE, branch: BR_NEXT,   target: PC_LATCH};
            4'd10:   w = '{op: OP_EMIT,     hold: WAIT_OUT,  branch: BR_ALWAYS, target: PC_LATCH};
            default: w = '{op: OP_NOP,      hold: WAIT_NONE, branch: BR_ALWAYS, target: PC_LATCH};
        endcase
        return w;
    endfunction

    // atan(2^-i) in Q2.30, truncated
    function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        v = 32'd0;
        case (idx)
            5'd0:    v = 32'd843314856;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043836;
            5'd3:    v = 32'd133525158;
            5'd4:    v = 32'd67021686;
            5'd5:    v = 32'd33543515;
            5'd6:    v = 32'd16775850;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194282;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048575;
            5'd11:   v = 32'd524287;
            5'd12:   v = 32'd262143;
            5'd13:   v = 32'd131071;
            5'd14:   v = 32'd65535;
            5'd15:   v = 32'd32767;
            5'd16:   v = 32'd16383;
            5'd17:   v = 32'd8191;
            5'd18:   v = 32'd4095;
            5'd19:   v = 32'd2047;
            5'd20:   v = 32'd1023;
            5'd21:   v = 32'd511;
            5'd22:   v = 32'd255;
            5'd23:   v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/differential_drive_odometry.sv
// Differential-drive wheel odometry core: microcoded sequencer over a shared multiplier and CORDIC.
// A word accepted in step 0 passes through the travel, mix, turn, fold, CORDIC rotation, unfold
// and move steps; the emit step then writes its pose into the output register once it is free.
// A new word is taken only after the previous pose is emitted; the single shared multiplier and the
// CORDIC rotation loop, reusing one add/shift unit once per iteration, serve one word at a time.
// Reset: pose and last angles to zero, default radius and axis, step counter to the input wait.
module differential_drive_odometry (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] left_angle, [63:32] right_angle
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // [31:0] pose_x, [63:32] pose_y, [82:64] pose_yaw, zero pad
);

    // Sequencer state
    logic [ddo_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic [ddo_pkg::ITER_W-1:0] iter_reg, iter_next;
    ddo_pkg::ctrl_word_t        cw;
    logic                       go;
    logic                       iter_last;

    // Configuration and pose state
    logic [15:0]        radius_reg, radius_next;
    logic [23:0]        inv_axis_reg, inv_axis_next;
    logic [31:0]        last_left_reg, last_left_next;
    logic [31:0]        last_right_reg, last_right_next;
    logic [31:0]        pos_x_reg, pos_x_next;
    logic [31:0]        pos_y_reg, pos_y_next;
    logic signed [18:0] heading_reg, heading_next;

    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [87:0] m_tdata_reg, m_tdata_next;

    // Scratch datapath registers
    logic signed [31:0] dl_reg, dl_next;
    logic signed [31:0] dr_reg, dr_next;
    logic signed [32:0] tl_reg, tl_next;
    logic signed [32:0] tr_reg, tr_next;
    logic signed [32:0] mean_reg, mean_next;
    logic signed [33:0] diff_reg, diff_next;
    logic signed [19:0] turn_reg, turn_next;
    logic signed [33:0] cx_reg, cx_next;
    logic signed [33:0] cy_reg, cy_next;
    logic signed [33:0] cz_reg, cz_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] cos_reg, cos_next;
    logic signed [31:0] sin_reg, sin_next;

    // Shared multiplier
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] prod;
    logic signed [49:0] turn_full;

    // Helpers
    logic signed [33:0] sum_t;
    logic signed [20:0] fold_a;
    logic signed [20:0] h_raw;
    logic signed [18:0] cfg_head;
    logic signed [33:0] atan_v;

    assign cw        = ddo_pkg::prog_rom(pc_reg);
    assign iter_last = (iter_reg == ddo_pkg::ITER_W'(ddo_pkg::ITERS - 1));

    // Hold condition of the current step
    always_comb
    begin
        case (cw.hold)
            ddo_pkg::WAIT_IN:  go = s_tvalid;
            ddo_pkg::WAIT_OUT: go = !m_tvalid_reg || m_tready;
            default:           go = 1'b1;
        endcase
    end

    assign s_tready  = (cw.hold == ddo_pkg::WAIT_IN);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Multiplier operand select
    always_comb
    begin
        case (cw.op)
            ddo_pkg::OP_TRAVEL_L:
            begin
                mul_a = 34'(dl_reg);
                mul_b = $signed({16'd0, radius_reg});
            end
            ddo_pkg::OP_TRAVEL_R:
            begin
                mul_a = 34'(dr_reg);
                mul_b = $signed({16'd0, radius_reg});
            end
            ddo_pkg::OP_TURN:
            begin
                mul_a = diff_reg;
                mul_b = $signed({8'd0, inv_axis_reg});
            end
            ddo_pkg::OP_MOVE_X:
            begin
                mul_a = 34'(mean_reg);
                mul_b = cos_reg;
            end
            ddo_pkg::OP_MOVE_Y:
            begin
                mul_a = 34'(mean_reg);
                mul_b = sin_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod      = mul_a * mul_b;
    assign turn_full = prod[65:16];
    assign sum_t     = 34'(tl_reg) + 34'(tr_reg);
    assign atan_v    = $signed({2'b00, ddo_pkg::atan_q30(ddo_pkg::ATAN_IDX_W'(iter_reg))});
    assign h_raw     = 21'(heading_reg) - 21'(turn_reg);
    assign cfg_head  = cfg_data[18:0];

    // Quadrant fold of the heading for CORDIC
    always_comb
    begin
        if (heading_reg > ddo_pkg::HALF_PI_Q)
        begin
            fold_a = 21'(heading_reg) - 21'(ddo_pkg::PI_Q);
        end
        else if (heading_reg < -ddo_pkg::HALF_PI_Q)
        begin
            fold_a = 21'(heading_reg) + 21'(ddo_pkg::PI_Q);
        end
        else
        begin
            fold_a = 21'(heading_reg);
        end
    end

    // Sequencer next state
    always_comb
    begin
        pc_next   = pc_reg;
        iter_next = iter_reg;
        if (go)
        begin
            case (cw.branch)
                ddo_pkg::BR_LOOP:
                begin
                    if (iter_last)
                    begin
                        pc_next   = pc_reg + 1'b1;
                        iter_next = '0;
                    end
                    else
                    begin
                        pc_next   = cw.target;
                        iter_next = iter_reg + 1'b1;
                    end
                end
                ddo_pkg::BR_ALWAYS: pc_next = cw.target;
                default:            pc_next = pc_reg + 1'b1;
            endcase
        end
    end

    // Datapath next state
    always_comb
    begin
        radius_next     = radius_reg;
        inv_axis_next   = inv_axis_reg;
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        heading_next    = heading_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        dl_next         = dl_reg;
        dr_next         = dr_reg;
        tl_next         = tl_reg;
        tr_next         = tr_reg;
        mean_next       = mean_reg;
        diff_next       = diff_reg;
        turn_next       = turn_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        neg_next        = neg_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;

        if (go)
        begin
            case (cw.op)
                ddo_pkg::OP_LATCH:
                begin
                    dl_next         = s_tdata[31:0] - last_left_reg;
                    dr_next         = s_tdata[63:32] - last_right_reg;
                    last_left_next  = s_tdata[31:0];
                    last_right_next = s_tdata[63:32];
                end
                ddo_pkg::OP_TRAVEL_L: tl_next = prod[48:16];
                ddo_pkg::OP_TRAVEL_R: tr_next = prod[48:16];
                ddo_pkg::OP_MIX:
                begin
                    mean_next = sum_t[33:1];
                    diff_next = 34'(tr_reg) - 34'(tl_reg);
                end
                ddo_pkg::OP_TURN:
                begin
                    // saturate so that one wrap always suffices
                    if (turn_full > ddo_pkg::TWO_PI_Q)
                    begin
                        turn_next = 20'(ddo_pkg::TWO_PI_Q);
                    end
                    else if (turn_full < -ddo_pkg::TWO_PI_Q)
                    begin
                        turn_next = -20'(ddo_pkg::TWO_PI_Q);
                    end
                    else
                    begin
                        turn_next = turn_full[19:0];
                    end
                end
                ddo_pkg::OP_FOLD:
                begin
                    cx_next  = 34'(ddo_pkg::CORDIC_GAIN);
                    cy_next  = '0;
                    cz_next  = {34'(fold_a)} << 14;
                    neg_next = (heading_reg > ddo_pkg::HALF_PI_Q) ||
                               (heading_reg < -ddo_pkg::HALF_PI_Q);
                end
                ddo_pkg::OP_ROTATE:
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_next = cx_reg - (cy_reg >>> iter_reg);
                        cy_next = cy_reg + (cx_reg >>> iter_reg);
                        cz_next = cz_reg - atan_v;
                    end
                    else
                    begin
                        cx_next = cx_reg + (cy_reg >>> iter_reg);
                        cy_next = cy_reg - (cx_reg >>> iter_reg);
                        cz_next = cz_reg + atan_v;
                    end
                end
                ddo_pkg::OP_UNFOLD:
                begin
                    cos_next = neg_reg ? -cx_reg[31:0] : cx_reg[31:0];
                    sin_next = neg_reg ? -cy_reg[31:0] : cy_reg[31:0];
                end
                ddo_pkg::OP_MOVE_X: pos_x_next = pos_x_reg + prod[61:30];
                ddo_pkg::OP_MOVE_Y:
                begin
                    pos_y_next = pos_y_reg + prod[61:30];
                    // heading update and single wrap into [-pi, pi]
                    if (h_raw > ddo_pkg::PI_Q)
                    begin
                        heading_next = 19'(h_raw - 21'(ddo_pkg::TWO_PI_Q));
                    end
                    else if (h_raw < -ddo_pkg::PI_Q)
                    begin
                        heading_next = 19'(h_raw + 21'(ddo_pkg::TWO_PI_Q));
                    end
                    else
                    begin
                        heading_next = h_raw[18:0];
                    end
                end
                ddo_pkg::OP_EMIT:
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, heading_reg, pos_y_reg, pos_x_reg};
                end
                default:
                begin
                end
            endcase
        end

        // configuration writes; the host must issue them only while no word is in flight, unenforced by the core
        if (cfg_valid)
        begin
            case (cfg_index)
                ddo_pkg::REG_WHEEL_RADIUS: radius_next   = cfg_data[15:0];
                ddo_pkg::REG_INVERSE_AXIS: inv_axis_next = cfg_data[23:0];
                ddo_pkg::REG_START_X:      pos_x_next    = cfg_data;
                ddo_pkg::REG_START_Y:      pos_y_next    = cfg_data;
                ddo_pkg::REG_START_HEADING:
                begin
                    if (cfg_head > ddo_pkg::PI_Q)
                    begin
                        heading_next = 19'(ddo_pkg::PI_Q);
                    end
                    else if (cfg_head < -ddo_pkg::PI_Q)
                    begin
                        heading_next = -19'(ddo_pkg::PI_Q);
                    end
                    else
                    begin
                        heading_next = cfg_head;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= ddo_pkg::PC_LATCH;
            iter_reg       <= '0;
            radius_reg     <= ddo_pkg::RADIUS_RESET;
            inv_axis_reg   <= ddo_pkg::INV_AXIS_RESET;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            iter_reg       <= iter_next;
            radius_reg     <= radius_next;
            inv_axis_reg   <= inv_axis_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            heading_reg    <= heading_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload and scratch registers
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        dl_reg      <= dl_next;
        dr_reg      <= dr_next;
        tl_reg      <= tl_next;
        tr_reg      <= tr_next;
        mean_reg    <= mean_next;
        diff_reg    <= diff_next;
        turn_reg    <= turn_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        neg_reg     <= neg_next;
        cos_reg     <= cos_next;
        sin_reg     <= sin_next;
    end

`ifndef SYNTHESIS
    // heading stays wrapped
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        (heading_reg <= ddo_pkg::PI_Q) && (heading_reg >= -ddo_pkg::PI_Q))
        else $error("heading left [-pi, pi]");

    // an accepted word starts the program
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (pc_reg == ddo_pkg::PC_LATCH + 1'b1))
        else $error("accepted word did not start the program");

    // iteration counter only runs inside the rotation loop
    a_iter_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (iter_reg != '0) |-> (pc_reg == ddo_pkg::PC_ROTATE))
        else $error("CORDIC counter live outside rotation step");

    // emit step holds while the output word is still pending
    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == ddo_pkg::PC_EMIT && m_tvalid_reg && !m_tready)
        |=> (pc_reg == ddo_pkg::PC_EMIT))
        else $error("emit step left while output word pending");
`endif

endmodule
